@@ hdl/nwa_pkg.sv @@
package nwa_pkg;

    localparam int NWA_NUM_STATES = 64;
    localparam int NWA_MAX_EDGES  = 256;
    localparam int NWA_SYMBOL_BITS = 8;

    localparam int STATE_W = 6;

    typedef enum logic [2:0] {
        MODE_ADD_EDGE   = 3'd0,
        MODE_MARK_FINAL = 3'd1,
        MODE_CLEAR      = 3'd2,
        MODE_BEGIN_WORD = 3'd3,
        MODE_SYMBOL     = 3'd4,
        MODE_END_WORD   = 3'd5
    } mode_t;

endpackage

@@ hdl/nwa_edge_mem.sv @@
module nwa_edge_mem #(
    parameter int DEPTH = nwa_pkg::NWA_MAX_EDGES,
    parameter int AW    = 8,
    parameter int DW    = 20
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);
    import nwa_pkg::*;

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/nfa_word_acceptor_unit.sv @@
// channel   dir  tdata (low bit up)                      tuser
// s_axis    in   src_state[5:0] dst_state[11:6]          mode[2:0]
//                symbol[19:12], zero pad to 24
// m_axis    out  status[0] accepted[1] any_active[2],    -
//                zero pad to 8
// cfg       in   cfg_wdata = start_state[5:0], written when cfg_we is high
//
// symbol: one stored edge per cycle through the single read port of the
// edge table; the walk is skipped when the table is empty
// reset clears edge count, final and active sets and start state; the
// edge table itself is not cleared, only entries below the count are read
// a result waits in the output register; the next item is taken meanwhile
module nfa_word_acceptor_unit #(
    parameter int NUM_STATES  = nwa_pkg::NWA_NUM_STATES,
    parameter int MAX_EDGES   = nwa_pkg::NWA_MAX_EDGES,
    parameter int SYMBOL_BITS = nwa_pkg::NWA_SYMBOL_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // src_state, dst_state, symbol
    input  logic [2:0]  s_axis_tuser,   // mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // status, accepted, any_active
    input  logic        cfg_we,
    input  logic [5:0]  cfg_wdata
);
    import nwa_pkg::*;

    localparam int CW = $clog2(MAX_EDGES + 1);
    localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int DW = 2 * STATE_W + SYMBOL_BITS;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_WALK  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_RESP  = 4'b1000
    } state_t;

    state_t                  state_reg, state_next;
    logic [CW-1:0]           count_reg, count_next;
    logic [NUM_STATES-1:0]   final_reg, final_next;
    logic [NUM_STATES-1:0]   active_reg, active_next;
    logic [NUM_STATES-1:0]   acc_reg, acc_next;
    logic [STATE_W-1:0]      start_reg;
    logic [AW-1:0]           addr_reg, addr_next;
    logic                    rvld_reg, rvld_next;
    logic [SYMBOL_BITS-1:0]  sym_reg, sym_next;
    logic                    status_reg, status_next;
    logic                    accepted_reg, accepted_next;
    logic                    m_valid_reg, m_valid_next;
    logic [2:0]              m_data_reg, m_data_next;

    mode_t                   in_mode;
    logic [STATE_W-1:0]      in_src;
    logic [STATE_W-1:0]      in_dst;
    logic [SYMBOL_BITS-1:0]  in_sym;

    logic                    mem_we;
    logic                    mem_re;
    logic [DW-1:0]           mem_rdata;
    logic [STATE_W-1:0]      rd_src;
    logic [STATE_W-1:0]      rd_dst;
    logic [SYMBOL_BITS-1:0]  rd_lbl;
    logic                    hit;
    logic [NUM_STATES-1:0]   acc_eval;

    function automatic logic [NUM_STATES-1:0] state_bit(input logic [STATE_W-1:0] s);
        logic [NUM_STATES-1:0] b;
        b = '0;
        for (int i = 0; i < NUM_STATES; i++)
        begin
            b[i] = (s == STATE_W'(i));
        end
        return b;
    endfunction

    assign in_mode = mode_t'(s_axis_tuser);
    assign in_src  = s_axis_tdata[STATE_W-1:0];
    assign in_dst  = s_axis_tdata[2*STATE_W-1:STATE_W];
    assign in_sym  = s_axis_tdata[2*STATE_W +: SYMBOL_BITS];

    nwa_edge_mem #(
        .DEPTH (MAX_EDGES),
        .AW    (AW),
        .DW    (DW)
    ) u_edge_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (count_reg[AW-1:0]),
        .wdata ({in_sym, in_dst, in_src}),
        .re    (mem_re),
        .raddr (addr_reg),
        .rdata (mem_rdata)
    );

    assign rd_src = mem_rdata[STATE_W-1:0];
    assign rd_dst = mem_rdata[2*STATE_W-1:STATE_W];
    assign rd_lbl = mem_rdata[DW-1:2*STATE_W];

    // one edge per cycle against the set that was active before the symbol
    assign hit = rvld_reg && (|(active_reg & state_bit(rd_src))) && (rd_lbl == sym_reg);
    assign acc_eval = acc_reg | (hit ? state_bit(rd_dst) : '0);

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        final_next    = final_reg;
        active_next   = active_reg;
        acc_next      = acc_reg;
        addr_next     = addr_reg;
        rvld_next     = 1'b0;
        sym_next      = sym_reg;
        status_next   = status_reg;
        accepted_next = accepted_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        mem_we        = 1'b0;
        mem_re        = 1'b0;

        if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    status_next   = 1'b0;
                    accepted_next = 1'b0;
                    state_next    = ST_RESP;
                    unique case (in_mode)
                        MODE_ADD_EDGE:
                        begin
                            if (count_reg < CW'(MAX_EDGES))
                            begin
                                mem_we     = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                            else
                            begin
                                status_next = 1'b1;
                            end
                        end
                        MODE_MARK_FINAL:
                        begin
                            final_next = final_reg | state_bit(in_src);
                        end
                        MODE_CLEAR:
                        begin
                            count_next  = '0;
                            final_next  = '0;
                            active_next = '0;
                        end
                        MODE_BEGIN_WORD:
                        begin
                            active_next = state_bit(start_reg);
                        end
                        MODE_SYMBOL:
                        begin
                            sym_next  = in_sym;
                            acc_next  = '0;
                            addr_next = '0;
                            if (count_reg == '0)
                            begin
                                active_next = '0;
                            end
                            else
                            begin
                                state_next = ST_WALK;
                            end
                        end
                        MODE_END_WORD:
                        begin
                            accepted_next = |(active_reg & final_reg);
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                mem_re    = 1'b1;
                rvld_next = 1'b1;
                acc_next  = acc_eval;
                addr_next = addr_reg + AW'(1);
                if (CW'(addr_reg) == count_reg - CW'(1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                active_next = acc_eval;
                state_next  = ST_RESP;
            end
            ST_RESP:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {|active_reg, accepted_reg, status_reg};
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            final_reg   <= '0;
            active_reg  <= '0;
            start_reg   <= '0;
            rvld_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            final_reg   <= final_next;
            active_reg  <= active_next;
            rvld_reg    <= rvld_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we)
            begin
                start_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg      <= acc_next;
        addr_reg     <= addr_next;
        sym_reg      <= sym_next;
        status_reg   <= status_next;
        accepted_reg <= accepted_next;
        m_data_reg   <= m_data_next;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {5'b0, m_data_reg};

endmodule

@@ hdl/nwa_checker.sv @@
module nwa_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // one item in flight: no transaction right after a transaction
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken on consecutive cycles");

    // a full table answer never comes with an acceptance
    a_status_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
        else $error("status and accepted both set");

    // acceptance needs an active state
    a_accept_active: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[1] |-> m_axis_tdata[2])
        else $error("accepted with empty active set");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[7:3] == 5'b0)
        else $error("nonzero pad bits in result");

endmodule

bind nfa_word_acceptor_unit nwa_checker u_nwa_checker (.*);

@@ verif/nfa_word_acceptor_unit_tb.sv @@
`timescale 1ns / 1ps

module nfa_word_acceptor_unit_tb;
    import nwa_pkg::*;

    localparam logic [2:0] MODE_SPARE_6 = 3'd6;
    localparam logic [2:0] MODE_SPARE_7 = 3'd7;
    localparam logic [7:0] SYM_MASK     = 8'((1 << NWA_SYMBOL_BITS) - 1);
    localparam int ITEM_TARGET    = 1500;
    localparam int STALL_PCT      = 11;
    localparam int NOISE_PCT      = 8;
    localparam int DRAIN_CYCLES   = NWA_MAX_EDGES + 8;
    localparam int WATCHDOG_LIMIT = 8 * (NWA_MAX_EDGES + 3) + 1000;

    typedef struct packed {
        logic any_active;
        logic accepted;
        logic status;
    } verdict_t;

    class nfa_shadow;
        logic [5:0] edge_src [NWA_MAX_EDGES];
        logic [5:0] edge_dst [NWA_MAX_EDGES];
        logic [7:0] edge_label [NWA_MAX_EDGES];
        int unsigned edge_total = 0;
        logic [63:0] final_set  = '0;
        logic [63:0] active_set = '0;
        logic [5:0]  start_idx  = '0;
        verdict_t pending[$];
        int unsigned errors = 0;
        int unsigned results = 0;
        int unsigned words = 0;
        int unsigned hits = 0;
        int unsigned overflows = 0;

        function logic [63:0] state_bit(logic [5:0] s);
            return (s < NWA_NUM_STATES) ? (64'd1 << s) : 64'd0;
        endfunction

        function void take_item(logic [2:0] mode, logic [5:0] src, logic [5:0] dst,
                                logic [7:0] sym);
            verdict_t want;
            logic [63:0] next_set;
            logic [7:0] key;
            want = '0;
            key = sym & SYM_MASK;
            case (mode)
                MODE_ADD_EDGE:
                begin
                    if (edge_total < NWA_MAX_EDGES)
                    begin
                        edge_src[edge_total]   = src;
                        edge_dst[edge_total]   = dst;
                        edge_label[edge_total] = key;
                        edge_total++;
                    end
                    else
                    begin
                        want.status = 1'b1;
                        overflows++;
                    end
                end
                MODE_MARK_FINAL:
                    final_set |= state_bit(src);
                MODE_CLEAR:
                begin
                    edge_total = 0;
                    final_set  = '0;
                    active_set = '0;
                end
                MODE_BEGIN_WORD:
                    active_set = state_bit(start_idx);
                MODE_SYMBOL:
                begin
                    next_set = '0;
                    for (int e = 0; e < edge_total; e++)
                    begin
                        if ((active_set & state_bit(edge_src[e])) != 0 && edge_label[e] == key)
                            next_set |= state_bit(edge_dst[e]);
                    end
                    active_set = next_set;
                end
                MODE_END_WORD:
                begin
                    want.accepted = ((active_set & final_set) != 0);
                    words++;
                    if (want.accepted)
                        hits++;
                end
                default:
                    ;
            endcase
            want.any_active = (active_set != 0);
            pending.insert(pending.size(), want);
        endfunction

        function void match_result(logic [7:0] data);
            verdict_t got;
            verdict_t want;
            got = verdict_t'(data[2:0]);
            results++;
            if (pending.size() == 0)
            begin
                errors++;
                $display("%0t: result with nothing pending, expected none, actual %b",
                         $time, data);
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status)
            begin
                errors++;
                $display("%0t: status mismatch, expected %b, actual %b",
                         $time, want.status, got.status);
            end
            if (got.accepted !== want.accepted)
            begin
                errors++;
                $display("%0t: accepted mismatch, expected %b, actual %b",
                         $time, want.accepted, got.accepted);
            end
            if (got.any_active !== want.any_active)
            begin
                errors++;
                $display("%0t: any_active mismatch, expected %b, actual %b",
                         $time, want.any_active, got.any_active);
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;   // src_state, dst_state, symbol
    logic [2:0]  s_axis_tuser = '0;   // mode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;        // status, accepted, any_active
    logic        cfg_we = 1'b0;
    logic [5:0]  cfg_wdata = '0;

    bit calm = 1'b0;
    int unsigned items_sent = 0;
    int unsigned quiet_cycles = 0;
    int unsigned phases_run = 0;
    nfa_shadow board = new();

    nfa_word_acceptor_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic bit stall_roll();
        return !calm && ($urandom_range(99) < STALL_PCT);
    endfunction

    always @(posedge clk)
    begin
        m_axis_tready <= !stall_roll();
    end

    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            board.take_item(s_axis_tuser, s_axis_tdata[5:0], s_axis_tdata[11:6],
                            s_axis_tdata[19:12]);
        if (rst_n && m_axis_tvalid && m_axis_tready)
            board.match_result(m_axis_tdata);
        if (rst_n && cfg_we)
            board.start_idx = cfg_wdata;
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic send_item(input logic [2:0] mode, input logic [5:0] src,
                             input logic [5:0] dst, input logic [7:0] sym);
        while (stall_roll())
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'd0, sym, dst, src};
        s_axis_tuser  <= mode;
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (mode <= MODE_END_WORD)
            items_sent++;
    endtask

    // a random transaction slips in now and then: spare modes, stray clears, unbegun words
    task automatic send_shaped(input logic [2:0] mode, input logic [5:0] src,
                               input logic [5:0] dst, input logic [7:0] sym);
        if ($urandom_range(99) < NOISE_PCT)
            send_item(3'($urandom_range(7)), 6'($urandom), 6'($urandom), 8'($urandom));
        send_item(mode, src, dst, sym);
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic load_start(input logic [5:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic random_phase(input logic [5:0] start, input bit fill);
        logic [5:0] pool [8];
        logic [7:0] alphabet [4];
        int n_edges;
        int n_words;
        int len;
        pool[0] = start;
        for (int i = 1; i < 8; i++)
            pool[i] = 6'($urandom);
        for (int i = 0; i < 4; i++)
            alphabet[i] = 8'($urandom);
        if (fill || $urandom_range(7) != 0)
            send_shaped(MODE_CLEAR, 6'($urandom), 6'($urandom), 8'($urandom));
        n_edges = fill ? NWA_MAX_EDGES + $urandom_range(1, 4) : $urandom_range(1, 24);
        repeat (n_edges)
            send_shaped(MODE_ADD_EDGE, pool[$urandom_range(7)], pool[$urandom_range(7)],
                        alphabet[$urandom_range(3)]);
        repeat ($urandom_range(1, 3))
            send_shaped(MODE_MARK_FINAL, pool[$urandom_range(7)], 6'($urandom), 8'($urandom));
        n_words = fill ? 4 : $urandom_range(3, 8);
        repeat (n_words)
        begin
            if ($urandom_range(9) != 0)
                send_shaped(MODE_BEGIN_WORD, 6'($urandom), 6'($urandom), 8'($urandom));
            len = $urandom_range(0, 6);
            repeat (len)
                send_shaped(MODE_SYMBOL, 6'($urandom), 6'($urandom),
                            ($urandom_range(9) == 0) ? 8'($urandom)
                                                     : alphabet[$urandom_range(3)]);
            send_shaped(MODE_END_WORD, 6'($urandom), 6'($urandom), 8'($urandom));
        end
    endtask

    initial
    begin
        int phase;
        logic [5:0] start;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        load_start(6'd0);
        send_item(MODE_CLEAR,      6'd0,  6'd0,  8'h00);
        send_item(MODE_SYMBOL,     6'd0,  6'd0,  8'h00);
        send_item(MODE_BEGIN_WORD, 6'd0,  6'd0,  8'h00);
        send_item(MODE_END_WORD,   6'd0,  6'd0,  8'h00);
        send_item(MODE_ADD_EDGE,   6'd0,  6'd63, 8'h00);
        send_item(MODE_ADD_EDGE,   6'd63, 6'd0,  8'hff);
        send_item(MODE_ADD_EDGE,   6'd63, 6'd63, 8'hff);
        send_item(MODE_MARK_FINAL, 6'd63, 6'd0,  8'h00);
        send_item(MODE_SYMBOL,     6'd63, 6'd63, 8'h00);
        send_item(MODE_END_WORD,   6'd0,  6'd0,  8'h00);
        send_item(MODE_SYMBOL,     6'd0,  6'd0,  8'hff);
        send_item(MODE_SPARE_6,    6'd63, 6'd63, 8'hff);
        send_item(MODE_SYMBOL,     6'd0,  6'd0,  8'h5a);
        send_item(MODE_END_WORD,   6'd63, 6'd63, 8'hff);
        send_item(MODE_SPARE_7,    6'd0,  6'd0,  8'h00);
        send_item(MODE_CLEAR,      6'd63, 6'd63, 8'hff);
        settle();

        load_start(6'd63);
        send_item(MODE_MARK_FINAL, 6'd0,  6'd0,  8'h00);
        send_item(MODE_ADD_EDGE,   6'd63, 6'd0,  8'h80);
        send_item(MODE_BEGIN_WORD, 6'd0,  6'd0,  8'h00);
        send_item(MODE_SYMBOL,     6'd0,  6'd0,  8'h80);
        send_item(MODE_END_WORD,   6'd0,  6'd0,  8'h00);
        send_item(MODE_BEGIN_WORD, 6'd0,  6'd0,  8'h00);
        send_item(MODE_END_WORD,   6'd0,  6'd0,  8'h00);
        send_item(MODE_CLEAR,      6'd0,  6'd0,  8'h00);

        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            settle();
            calm <= (phase >= 5 && phase < 8);
            case (phase % 3)
                0: start = 6'd0;
                1: start = 6'd63;
                default: start = 6'($urandom);
            endcase
            load_start(start);
            random_phase(start, phase == 2);
            phase++;
        end
        phases_run = phase;
        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d input transactions and %0d results over %0d random phases",
                 items_sent, board.results, phases_run);
        $display("%0d words ended, %0d accepted, %0d edge inserts dropped on a full table",
                 board.words, board.hits, board.overflows);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ nfa_word_acceptor_unit.f @@
hdl/nwa_pkg.sv
hdl/nwa_edge_mem.sv
hdl/nfa_word_acceptor_unit.sv
hdl/nwa_checker.sv
verif/nfa_word_acceptor_unit_tb.sv
